@@ sv/rbf_pkg.sv @@
// Shared types and constants for the byte ring FIFO with drop count.
package rbf_pkg;

  localparam int unsigned STORE_DEPTH_DEFAULT = 64;
  localparam logic [6:0]  RING_SIZE_RESET     = 7'd64;
  localparam logic [15:0] DROP_MAX            = 16'hFFFF;
  localparam logic [5:0]  COUNT_MAX           = 6'd63;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_FRAME = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // Result of one transaction, held between the control stage and the output register.
  typedef struct packed {
    logic        valid;
    logic        ok;
    logic        get_ok;
    logic        is_empty;
    logic [5:0]  fill_count;
    logic [5:0]  free_space;
    logic [15:0] drop_count;
  } pend_t;

endpackage

@@ sv/rbf_item_if.sv @@
// Input channel: one operation per transaction.
interface rbf_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;
  logic [7:0] frame_length;

  modport source (output valid, output op, output data_byte, output frame_length,
                  input ready);
  modport sink (input valid, input op, input data_byte, input frame_length,
                output ready);
endinterface

@@ sv/rbf_result_if.sv @@
// Output channel: one status result per transaction.
interface rbf_result_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [7:0]  read_byte;
  logic        is_empty;
  logic [5:0]  fill_count;
  logic [5:0]  free_space;
  logic [15:0] drop_count;

  modport source (output valid, output ok, output read_byte, output is_empty,
                  output fill_count, output free_space, output drop_count, input ready);
  modport sink (input valid, input ok, input read_byte, input is_empty,
                input fill_count, input free_space, input drop_count, output ready);
endinterface

@@ sv/rbf_store.sv @@
// Byte storage of the ring: one write port and one registered read port.
module rbf_store
  import rbf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEFAULT,
  localparam int unsigned PW = $clog2(STORE_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [PW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [PW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ sv/rbf_ctrl.sv @@
// Pointer, drop counter and size control; issues store accesses and holds one pending result.
module rbf_ctrl
  import rbf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEFAULT,
  localparam int unsigned PW = $clog2(STORE_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [6:0]    cfg_wr_data,
  input  logic          accept,
  input  logic [1:0]    op,
  input  logic [7:0]    frame_length,
  input  logic          pend_take,
  output pend_t         pend,
  output logic          wr_en,
  output logic [PW-1:0] wr_addr,
  output logic          rd_en,
  output logic [PW-1:0] rd_addr
);

  localparam int unsigned SW = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CW = (SW > 8) ? SW : 8;

  logic [6:0]    ring_size;
  logic [PW-1:0] write_pointer, write_pointer_next;
  logic [PW-1:0] read_pointer, read_pointer_next;
  logic [15:0]   drops, drops_next;
  pend_t         pend_next;

  logic [CW-1:0] size_ext;
  logic [SW-1:0] size;
  logic [SW-1:0] wp_inc, rp_inc;
  logic [PW-1:0] wp_adv, rp_adv;
  logic [SW-1:0] held_now, room, held_after;
  logic [CW-1:0] held_ext, free_ext;
  logic          full, empty, fits;

  // A size of zero acts as one; anything above the store depth acts as the depth.
  always_comb begin
    size_ext = CW'(ring_size);
    if (size_ext == '0) begin
      size = SW'(1);
    end else if (size_ext > CW'(STORE_DEPTH)) begin
      size = SW'(STORE_DEPTH);
    end else begin
      size = size_ext[SW-1:0];
    end
  end

  assign wp_inc = SW'(write_pointer) + SW'(1);
  assign rp_inc = SW'(read_pointer) + SW'(1);
  assign wp_adv = (wp_inc == size) ? '0 : wp_inc[PW-1:0];
  assign rp_adv = (rp_inc == size) ? '0 : rp_inc[PW-1:0];
  assign full   = (wp_adv == read_pointer);
  assign empty  = (write_pointer == read_pointer);

  assign held_now = (write_pointer >= read_pointer)
                  ? SW'(write_pointer) - SW'(read_pointer)
                  : size - (SW'(read_pointer) - SW'(write_pointer));
  assign room = size - SW'(1) - held_now;
  assign fits = (CW'(room) >= CW'(frame_length));

  assign wr_en   = accept && (op_t'(op) == OP_PUT) && !full;
  assign wr_addr = write_pointer;
  assign rd_en   = accept && (op_t'(op) == OP_GET) && !empty;
  assign rd_addr = read_pointer;

  always_comb begin
    write_pointer_next = write_pointer;
    read_pointer_next  = read_pointer;
    drops_next         = drops;
    pend_next          = pend;
    if (pend_take) begin
      pend_next.valid = 1'b0;
    end
    if (accept) begin
      pend_next.valid  = 1'b1;
      pend_next.ok     = 1'b0;
      pend_next.get_ok = 1'b0;
      unique case (op_t'(op))
        OP_PUT: begin
          if (!full) begin
            write_pointer_next = wp_adv;
            pend_next.ok       = 1'b1;
          end
        end
        OP_GET: begin
          if (!empty) begin
            read_pointer_next = rp_adv;
            pend_next.ok      = 1'b1;
            pend_next.get_ok  = 1'b1;
          end
        end
        OP_FRAME: begin
          if (fits) begin
            pend_next.ok = 1'b1;
          end else if (drops != DROP_MAX) begin
            drops_next = drops + 16'd1;
          end
        end
        OP_CLEAR: begin
          write_pointer_next = '0;
          read_pointer_next  = '0;
          drops_next         = '0;
        end
        default: begin
        end
      endcase
    end
    held_after = (write_pointer_next >= read_pointer_next)
               ? SW'(write_pointer_next) - SW'(read_pointer_next)
               : size - (SW'(read_pointer_next) - SW'(write_pointer_next));
    held_ext = CW'(held_after);
    free_ext = CW'(size - SW'(1) - held_after);
    if (accept) begin
      pend_next.is_empty   = (write_pointer_next == read_pointer_next);
      pend_next.fill_count = (held_ext > CW'(COUNT_MAX)) ? COUNT_MAX : held_ext[5:0];
      pend_next.free_space = (free_ext > CW'(COUNT_MAX)) ? COUNT_MAX : free_ext[5:0];
      pend_next.drop_count = drops_next;
    end
  end

  always_ff @(posedge clk) begin
    pend.ok         <= pend_next.ok;
    pend.get_ok     <= pend_next.get_ok;
    pend.is_empty   <= pend_next.is_empty;
    pend.fill_count <= pend_next.fill_count;
    pend.free_space <= pend_next.free_space;
    pend.drop_count <= pend_next.drop_count;
    if (rst) begin
      ring_size     <= RING_SIZE_RESET;
      write_pointer <= '0;
      read_pointer  <= '0;
      drops         <= '0;
      pend.valid    <= 1'b0;
    end else if (cfg_wr_en) begin
      // A size change restarts the ring so the pointers stay inside it.
      ring_size     <= cfg_wr_data;
      write_pointer <= '0;
      read_pointer  <= '0;
      drops         <= '0;
      pend.valid    <= pend_next.valid;
    end else begin
      write_pointer <= write_pointer_next;
      read_pointer  <= read_pointer_next;
      drops         <= drops_next;
      pend.valid    <= pend_next.valid;
    end
  end

endmodule

@@ sv/byte_ring_fifo_with_drop_count.sv @@
// Each accepted transaction's result is registered in the pending stage, then in the output register.
// Throughput: one transaction per cycle while results are taken; the byte store's
// registered read port is why a result passes through the pending stage before output.
// Reset (rst, synchronous): pointers and drop count go to zero, ring_size to 64,
// and both result stages empty. Byte store contents are not cleared.
module byte_ring_fifo_with_drop_count
  import rbf_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [6:0]   cfg_wr_data,
  rbf_item_if.sink     items,
  rbf_result_if.source results
);

  localparam int unsigned PW = $clog2(STORE_DEPTH);

  pend_t         pend;
  logic          accept, move;
  logic          wr_en, rd_en;
  logic [PW-1:0] wr_addr, rd_addr;
  logic [7:0]    rd_data;

  // The pending result moves on whenever the output register is free or being emptied.
  assign move         = pend.valid && (!results.valid || results.ready);
  assign items.ready  = !pend.valid || move;
  assign accept       = items.valid && items.ready;

  rbf_ctrl #(.STORE_DEPTH(STORE_DEPTH)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .accept       (accept),
    .op           (items.op),
    .frame_length (items.frame_length),
    .pend_take    (move),
    .pend         (pend),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr)
  );

  rbf_store #(.STORE_DEPTH(STORE_DEPTH)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (items.data_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (move) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      results.ok         <= pend.ok;
      results.read_byte  <= pend.get_ok ? rd_data : 8'd0;
      results.is_empty   <= pend.is_empty;
      results.fill_count <= pend.fill_count;
      results.free_space <= pend.free_space;
      results.drop_count <= pend.drop_count;
    end
  end

endmodule
